[design/mpsm_pkg.sv]
// Shared types and constants for the multi-pattern string matcher.
package mpsm_pkg;

  localparam int NodeCount = 256;
  localparam int MaxDepth  = 32;
  localparam int ResultCap = 32;
  localparam int NodeW     = $clog2(NodeCount);
  localparam int UsedW     = $clog2(NodeCount + 1);
  localparam int DepthW    = $clog2(MaxDepth + 1);
  localparam int GuardW    = $clog2(MaxDepth + 2);
  localparam int CapW      = $clog2(ResultCap + 1);
  localparam int NodeRamW  = NodeW + 16 + 1 + 7 + DepthW;

  localparam logic [2:0] OpAdd   = 3'd0;
  localparam logic [2:0] OpEnd   = 3'd1;
  localparam logic [2:0] OpBuild = 3'd2;
  localparam logic [2:0] OpScan  = 3'd3;
  localparam logic [2:0] OpText  = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StTooLong = 2'd2;
  localparam logic [1:0] StNoLinks = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] code_unit;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [31:0] match_start;
    logic [6:0]  match_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [NodeW-1:0]  parent;
    logic [15:0]       label;
    logic              terminal;
    logic [6:0]        byte_len;
    logic [DepthW-1:0] depth;
  } node_t;

  // controller -> datapath
  typedef struct packed {
    logic             scan_rd;     // read search node
    logic [NodeW-1:0] scan_addr;
    logic             info_rd;     // read node info
    logic [NodeW-1:0] info_addr;
    logic             fail_rd;
    logic [NodeW-1:0] fail_addr;
  } mpsm_cmd_t;

  typedef struct packed {
    node_t            scan_node;
    node_t            info_node;
    logic [NodeW-1:0] fail_data;
  } mpsm_sts_t;

  function automatic logic [1:0] unit_bytes(input logic [15:0] u);
    if (u <= 16'h007f) return 2'd1;
    if (u <= 16'h07ff) return 2'd2;
    return 2'd3;
  endfunction

endpackage

[design/mpsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mpsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

[design/mpsm_datapath.sv]
// Node store memories of the matcher: node records and failure links.
module mpsm_datapath
  import mpsm_pkg::*;
(
  input  logic             clk_i,
  input  mpsm_cmd_t        cmd_i,
  input  logic             node_we_i,
  input  logic [NodeW-1:0] node_waddr_i,
  input  node_t            node_wdata_i,
  input  logic             fail_we_i,
  input  logic [NodeW-1:0] fail_waddr_i,
  input  logic [NodeW-1:0] fail_wdata_i,
  output mpsm_sts_t        sts_o
);
  logic [NodeRamW-1:0] scan_rdata, info_rdata;

  // two copies of node records give two read ports
  mpsm_ram #(.Width(NodeRamW), .Depth(NodeCount)) u_node_a (
    .clk_i, .we_i(node_we_i), .waddr_i(node_waddr_i), .wdata_i(node_wdata_i),
    .re_i(cmd_i.scan_rd), .raddr_i(cmd_i.scan_addr), .rdata_o(scan_rdata)
  );
  mpsm_ram #(.Width(NodeRamW), .Depth(NodeCount)) u_node_b (
    .clk_i, .we_i(node_we_i), .waddr_i(node_waddr_i), .wdata_i(node_wdata_i),
    .re_i(cmd_i.info_rd), .raddr_i(cmd_i.info_addr), .rdata_o(info_rdata)
  );
  mpsm_ram #(.Width(NodeW), .Depth(NodeCount)) u_fail (
    .clk_i, .we_i(fail_we_i), .waddr_i(fail_waddr_i), .wdata_i(fail_wdata_i),
    .re_i(cmd_i.fail_rd), .raddr_i(cmd_i.fail_addr), .rdata_o(sts_o.fail_data)
  );

  assign sts_o.scan_node = node_t'(scan_rdata);
  assign sts_o.info_node = node_t'(info_rdata);
endmodule

[design/mpsm_ctrl.sv]
// Sequencer of the matcher: insert, link build, scan and report beats.
module mpsm_ctrl
  import mpsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  output mpsm_cmd_t        cmd_o,
  input  mpsm_sts_t        sts_i,
  output logic             node_we_o,
  output logic [NodeW-1:0] node_waddr_o,
  output node_t            node_wdata_o,
  output logic             fail_we_o,
  output logic [NodeW-1:0] fail_waddr_o,
  output logic [NodeW-1:0] fail_wdata_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_ADD_DO, S_END_RD, S_END_W,
    S_B_LVL, S_B_NODE, S_B_NODE_W, S_B_PFAIL, S_B_PFAIL_W, S_B_CHK, S_B_FAIL_W,
    S_S_CHK, S_S_FAIL_W, S_S_REP, S_S_REP_W, S_S_TFAIL_W, S_OUT, S_DRAIN
  } state_e;

  // which activity a child search serves
  typedef enum logic [1:0] { C_ADD, C_BUILD, C_SCAN } caller_e;

  state_e            state_q;
  caller_e           caller_q;
  in_item_t          item_q;
  logic [UsedW-1:0]  used_q;
  logic [NodeW-1:0]  cursor_q, scan_q, cur_q, back_q, srch_p_q, t_q, bn_q;
  logic [15:0]       srch_u_q;
  logic [6:0]        ibytes_q;
  logic [DepthW-1:0] idepth_q, lvl_q;
  logic [1:0]        ierr_q;
  logic              links_q;
  logic [31:0]       offset_q;
  logic [UsedW-1:0]  n_q;
  logic [NodeW-1:0]  found_q;
  logic              hit_q;
  logic [GuardW-1:0] guard_q;
  logic [CapW-1:0]   k_q;
  logic              have_q;
  out_item_t         pend_q, obuf_q;
  logic              oval_q;
  node_t             bnode_q;
  logic [1:0]        ulen;

  assign ulen        = unit_bytes(item_q.code_unit);
  assign in_ready_o  = (state_q == S_IDLE) && !oval_q;
  assign out_valid_o = oval_q;
  assign out_data_o  = obuf_q;

  // search visits node n_q; node read issued in S_SRCH, checked in S_SRCH_W
  always_comb begin
    cmd_o = '0;
    cmd_o.scan_rd   = (state_q == S_SRCH);
    cmd_o.scan_addr = n_q[NodeW-1:0];
    cmd_o.info_rd   = (state_q == S_B_NODE) || (state_q == S_S_REP) ||
                      (state_q == S_END_RD);
    cmd_o.info_addr = (state_q == S_S_REP) ? t_q :
                      (state_q == S_END_RD) ? cursor_q : n_q[NodeW-1:0];
    cmd_o.fail_rd   = (state_q == S_B_PFAIL) || (state_q == S_B_CHK) ||
                      (state_q == S_S_CHK) || (state_q == S_S_REP);
    cmd_o.fail_addr = (state_q == S_B_PFAIL) ? bnode_q.parent :
                      (state_q == S_B_CHK) ? back_q :
                      (state_q == S_S_REP) ? t_q : cur_q;
  end

  always_comb begin
    node_we_o          = (state_q == S_ADD_DO) && !hit_q && (used_q != UsedW'(NodeCount));
    node_waddr_o       = used_q[NodeW-1:0];
    node_wdata_o       = '0;
    node_wdata_o.parent = cursor_q;
    node_wdata_o.label  = item_q.code_unit;
    node_wdata_o.depth  = idepth_q + DepthW'(1);
    if (state_q == S_END_W) begin
      node_we_o            = 1'b1;
      node_waddr_o         = cursor_q;
      node_wdata_o         = sts_i.info_node;
      node_wdata_o.terminal = 1'b1;
      node_wdata_o.byte_len = ibytes_q;
    end
    fail_we_o    = 1'b0;
    fail_waddr_o = bn_q;
    fail_wdata_o = '0;
    if (state_q == S_ADD_DO) begin
      fail_we_o    = node_we_o;
      fail_waddr_o = used_q[NodeW-1:0];
    end else if (state_q == S_B_NODE_W && sts_i.info_node.depth == lvl_q &&
                 lvl_q == DepthW'(1) && n_q < used_q) begin
      fail_we_o    = 1'b1;
      fail_waddr_o = n_q[NodeW-1:0];
    end else if (state_q == S_B_CHK && (hit_q || back_q == '0 ||
                 guard_q == GuardW'(MaxDepth))) begin
      fail_we_o    = 1'b1;
      fail_wdata_o = hit_q ? found_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      caller_q <= C_ADD;
      item_q   <= '0;
      used_q   <= UsedW'(1);
      cursor_q <= '0;
      scan_q   <= '0;
      cur_q    <= '0;
      back_q   <= '0;
      srch_p_q <= '0;
      srch_u_q <= '0;
      t_q      <= '0;
      bn_q     <= '0;
      ibytes_q <= '0;
      idepth_q <= '0;
      lvl_q    <= '0;
      ierr_q   <= StOk;
      links_q  <= 1'b0;
      offset_q <= '0;
      n_q      <= '0;
      found_q  <= '0;
      hit_q    <= 1'b0;
      guard_q  <= '0;
      k_q      <= '0;
      have_q   <= 1'b0;
      pend_q   <= '0;
      obuf_q   <= '0;
      oval_q   <= 1'b0;
      bnode_q  <= '0;
    end else begin
      if (oval_q && out_ready_i) begin
        oval_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            item_q <= in_data_i;
            pend_q <= '0;
            pend_q.last <= 1'b1;
            case (in_data_i.op)
              OpAdd: begin
                if (ierr_q != StOk) begin
                  pend_q.status <= ierr_q;
                  state_q <= S_OUT;
                end else if (idepth_q == DepthW'(MaxDepth)) begin
                  ierr_q <= StTooLong;
                  pend_q.status <= StTooLong;
                  state_q <= S_OUT;
                end else begin
                  caller_q <= C_ADD;
                  srch_p_q <= cursor_q;
                  srch_u_q <= in_data_i.code_unit;
                  n_q      <= UsedW'(1);
                  hit_q    <= 1'b0;
                  state_q  <= S_SRCH;
                end
              end
              OpEnd: begin
                pend_q.status <= ierr_q;
                if (ierr_q == StOk && cursor_q != '0) begin
                  state_q <= S_END_RD;
                end else begin
                  cursor_q <= '0;
                  ibytes_q <= '0;
                  idepth_q <= '0;
                  ierr_q   <= StOk;
                  state_q  <= S_OUT;
                end
              end
              OpBuild: begin
                lvl_q   <= DepthW'(1);
                n_q     <= UsedW'(1);
                state_q <= S_B_LVL;
              end
              OpScan: begin
                if (!links_q) begin
                  pend_q.status <= StNoLinks;
                  state_q <= S_OUT;
                end else begin
                  cur_q   <= scan_q;
                  guard_q <= '0;
                  state_q <= S_S_CHK;
                end
              end
              OpText: begin
                scan_q   <= '0;
                offset_q <= '0;
                state_q  <= S_OUT;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        // linear child search: child of srch_p_q labelled srch_u_q
        S_SRCH: begin
          if (hit_q || n_q >= used_q) begin
            case (caller_q)
              C_ADD:   state_q <= S_ADD_DO;
              C_BUILD: state_q <= S_B_CHK;
              default: state_q <= S_S_CHK;
            endcase
          end else begin
            state_q <= S_SRCH_W;
          end
        end
        S_SRCH_W: begin
          if (sts_i.scan_node.parent == srch_p_q && sts_i.scan_node.label == srch_u_q) begin
            hit_q   <= 1'b1;
            found_q <= n_q[NodeW-1:0];
          end else begin
            n_q <= n_q + UsedW'(1);
          end
          state_q <= S_SRCH;
        end
        S_ADD_DO: begin
          if (hit_q) begin
            cursor_q <= found_q;
          end else if (used_q == UsedW'(NodeCount)) begin
            ierr_q <= StFull;
            pend_q.status <= StFull;
          end else begin
            cursor_q <= used_q[NodeW-1:0];
            used_q   <= used_q + UsedW'(1);
            links_q  <= 1'b0;
          end
          if (hit_q || used_q != UsedW'(NodeCount)) begin
            idepth_q <= idepth_q + DepthW'(1);
            ibytes_q <= ibytes_q + 7'(ulen);
          end
          state_q <= S_OUT;
        end
        S_END_RD: state_q <= S_END_W;
        S_END_W: begin
          cursor_q <= '0;
          ibytes_q <= '0;
          idepth_q <= '0;
          ierr_q   <= StOk;
          state_q  <= S_OUT;
        end
        // build: levels 1..MaxDepth, nodes in index order
        S_B_LVL: begin
          if (n_q >= used_q) begin
            if (lvl_q == DepthW'(MaxDepth)) begin
              links_q <= 1'b1;
              scan_q  <= '0;
              state_q <= S_OUT;
            end else begin
              lvl_q <= lvl_q + DepthW'(1);
              n_q   <= UsedW'(1);
            end
          end else begin
            state_q <= S_B_NODE;
          end
        end
        S_B_NODE: state_q <= S_B_NODE_W;
        S_B_NODE_W: begin
          bnode_q <= sts_i.info_node;
          bn_q    <= n_q[NodeW-1:0];
          if (sts_i.info_node.depth == lvl_q && lvl_q != DepthW'(1)) begin
            state_q <= S_B_PFAIL;
          end else begin
            n_q     <= n_q + UsedW'(1);
            state_q <= S_B_LVL;
          end
        end
        S_B_PFAIL: state_q <= S_B_PFAIL_W;
        S_B_PFAIL_W: begin
          back_q   <= sts_i.fail_data;
          guard_q  <= '0;
          caller_q <= C_BUILD;
          srch_p_q <= sts_i.fail_data;
          srch_u_q <= bnode_q.label;
          n_q      <= UsedW'(1);
          hit_q    <= 1'b0;
          state_q  <= S_SRCH;
        end
        // after search of back_q; fail write done combinationally when finished
        S_B_CHK: begin
          if (hit_q || back_q == '0 || guard_q == GuardW'(MaxDepth)) begin
            n_q     <= UsedW'(bn_q) + UsedW'(1);
            state_q <= S_B_LVL;
          end else begin
            state_q <= S_B_FAIL_W;
          end
        end
        S_B_FAIL_W: begin
          back_q   <= sts_i.fail_data;
          guard_q  <= guard_q + GuardW'(1);
          srch_p_q <= sts_i.fail_data;
          n_q      <= UsedW'(1);
          hit_q    <= 1'b0;
          state_q  <= S_SRCH;
        end
        // scan: hit_q/found_q hold search of cur_q when caller is scan
        S_S_CHK: begin
          if (caller_q != C_SCAN || srch_p_q != cur_q) begin
            caller_q <= C_SCAN;
            srch_p_q <= cur_q;
            srch_u_q <= item_q.code_unit;
            n_q      <= UsedW'(1);
            hit_q    <= 1'b0;
            state_q  <= S_SRCH;
          end else if (cur_q == '0 || hit_q || guard_q == GuardW'(MaxDepth + 1)) begin
            scan_q   <= hit_q ? found_q : '0;
            t_q      <= hit_q ? found_q : '0;
            caller_q <= C_ADD;
            guard_q  <= '0;
            k_q      <= '0;
            have_q   <= 1'b0;
            state_q  <= S_S_REP;
          end else begin
            state_q <= S_S_FAIL_W;
          end
        end
        S_S_FAIL_W: begin
          cur_q   <= sts_i.fail_data;
          guard_q <= guard_q + GuardW'(1);
          state_q <= S_S_CHK;
        end
        S_S_REP: begin
          if (t_q == '0 || guard_q == GuardW'(MaxDepth + 1)) begin
            offset_q <= offset_q + 32'(ulen);
            pend_q.last <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_S_REP_W;
          end
        end
        S_S_REP_W: begin
          if (sts_i.info_node.terminal && k_q != CapW'(ResultCap)) begin
            if (have_q) begin
              obuf_q <= pend_q;
              oval_q <= 1'b1;
            end
            have_q <= 1'b1;
            k_q    <= k_q + CapW'(1);
            pend_q.kind         <= 1'b1;
            pend_q.status       <= StOk;
            pend_q.match_start  <= offset_q + 32'(ulen) - 32'(sts_i.info_node.byte_len);
            pend_q.match_length <= sts_i.info_node.byte_len;
            pend_q.last         <= 1'b0;
          end
          t_q     <= sts_i.fail_data;
          guard_q <= guard_q + GuardW'(1);
          state_q <= have_q && sts_i.info_node.terminal && k_q != CapW'(ResultCap) ?
                     S_S_TFAIL_W : S_S_REP;
        end
        S_S_TFAIL_W: begin
          if (!oval_q || out_ready_i) begin
            state_q <= S_S_REP;
          end
        end
        S_OUT: begin
          if (!oval_q || out_ready_i) begin
            obuf_q  <= pend_q;
            oval_q  <= 1'b1;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[design/multi_pattern_string_matcher.sv]
// Top level of the multi-pattern string matcher.
// Aho-Corasick matcher over 16-bit code units with a 256-node store held in
// RAM. One item is handled at a time. A child lookup scans the node store
// linearly, one stored node after another, so an add or scan step costs up to
// one sweep of the used nodes per lookup; a scan adds one lookup per fail hop
// and a node read per output-chain node. A build sweeps the store once per
// trie level (32 levels), each deeper node adding a lookup per fail hop.
// Result beats leave through a one-deep output register.
module multi_pattern_string_matcher
  import mpsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
  mpsm_cmd_t        cmd;
  mpsm_sts_t        sts;
  logic             node_we, fail_we;
  logic [NodeW-1:0] node_waddr, fail_waddr, fail_wdata;
  node_t            node_wdata;

  mpsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cmd_o(cmd), .sts_i(sts),
    .node_we_o(node_we), .node_waddr_o(node_waddr), .node_wdata_o(node_wdata),
    .fail_we_o(fail_we), .fail_waddr_o(fail_waddr), .fail_wdata_o(fail_wdata)
  );

  mpsm_datapath u_dp (
    .clk_i, .cmd_i(cmd),
    .node_we_i(node_we), .node_waddr_i(node_waddr), .node_wdata_i(node_wdata),
    .fail_we_i(fail_we), .fail_waddr_i(fail_waddr), .fail_wdata_i(fail_wdata),
    .sts_o(sts)
  );
endmodule
